// ===== src/bcs_pkg.sv =====
package bcs_pkg;

   localparam int CNT_W     = 6;
   localparam int KEY_N     = 4;
   localparam int CHORD_N   = 5;
   localparam int CHORD_W   = 3;
   localparam int KEY_IDX_W = 2;

   // key bit positions
   localparam int KEY_ST1 = 0;
   localparam int KEY_ST2 = 1;
   localparam int KEY_ESC = 2;
   localparam int KEY_MOD = 3;

   localparam logic [KEY_N-1:0] KM_ST1 = 4'b0001;
   localparam logic [KEY_N-1:0] KM_ST2 = 4'b0010;
   localparam logic [KEY_N-1:0] KM_ESC = 4'b0100;
   localparam logic [KEY_N-1:0] KM_MOD = 4'b1000;
   localparam logic [KEY_N-1:0] KM_ALL = 4'b1111;

   // chord counter slots
   localparam logic [CHORD_W-1:0] CH_MS1 = 3'd0;
   localparam logic [CHORD_W-1:0] CH_MS2 = 3'd1;
   localparam logic [CHORD_W-1:0] CH_MES = 3'd2;
   localparam logic [CHORD_W-1:0] CH_S1E = 3'd3;
   localparam logic [CHORD_W-1:0] CH_S12 = 3'd4;

   localparam logic [CHORD_N-1:0] CM_MS1 = 5'b00001;
   localparam logic [CHORD_N-1:0] CM_MS2 = 5'b00010;
   localparam logic [CHORD_N-1:0] CM_MES = 5'b00100;
   localparam logic [CHORD_N-1:0] CM_S1E = 5'b01000;
   localparam logic [CHORD_N-1:0] CM_S12 = 5'b10000;

   localparam logic [CNT_W-1:0] TACT_RST  = 6'd5;
   localparam logic [CNT_W-1:0] LONG_RST  = 6'd30;
   localparam logic [CNT_W-1:0] LIMIT_RST = 6'd50;

   typedef enum logic [1:0] {
      CSR_TACT  = 2'd0,
      CSR_LONG  = 2'd1,
      CSR_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0] tact_threshold;
      logic [CNT_W-1:0] long_threshold;
      logic [CNT_W-1:0] limit_value;
   } bcs_cfg_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_N-1:0] button_levels;
   } bcs_stage_type;

endpackage

// ===== src/bcs_chan_if.sv =====
interface bcs_req_if import bcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_N-1:0] button_levels;

   modport source (output valid, output button_levels, input ready);
   modport sink   (input valid, input button_levels, output ready);
endinterface

interface bcs_rsp_if import bcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_N-1:0] short_press_mask;
   logic [KEY_N-1:0] long_press_mask;

   modport source (output valid, output short_press_mask, output long_press_mask, input ready);
   modport sink   (input valid, input short_press_mask, input long_press_mask, output ready);
endinterface

// ===== src/bcs_in_stage.sv =====
module bcs_in_stage import bcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   bcs_req_if.sink       req_chan,
   input  logic          core_ready,
   output bcs_stage_type stage
);

   logic             valid_ff;
   logic             valid_in;
   logic [KEY_N-1:0] levels_ff;
   logic             take;

   assign req_chan.ready = !valid_ff || core_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take || (valid_ff && !core_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         levels_ff <= req_chan.button_levels;
      end
   end

   assign stage.valid         = valid_ff;
   assign stage.button_levels = levels_ff;

endmodule

// ===== src/bcs_core.sv =====
module bcs_core import bcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  bcs_cfg_type   cfg,
   input  bcs_stage_type stage,
   output logic          core_ready,
   bcs_rsp_if.source     rsp_chan
);

   logic [CNT_W-1:0] single_cnt_ff [KEY_N];
   logic [CNT_W-1:0] single_cnt_in [KEY_N];
   logic [CNT_W-1:0] chord_cnt_ff  [CHORD_N];
   logic [CNT_W-1:0] chord_cnt_in  [CHORD_N];
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [KEY_N-1:0] short_ff;
   logic [KEY_N-1:0] short_in;
   logic [KEY_N-1:0] long_ff;
   logic [KEY_N-1:0] long_in;
   logic             fire;

   assign core_ready   = !rsp_valid_ff || rsp_chan.ready;
   assign fire         = stage.valid && core_ready;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      logic [KEY_N-1:0]     pressed;
      logic                 any_key;
      logic                 is_chord;
      logic [CHORD_W-1:0]   cidx;
      logic [KEY_IDX_W-1:0] sidx;
      logic [KEY_N-1:0]     clr_s;
      logic [CHORD_N-1:0]   clr_c;
      logic [KEY_N-1:0]     keys;
      logic [CNT_W-1:0]     cnt;

      pressed  = ~stage.button_levels;
      any_key  = |pressed;
      is_chord = 1'b1;
      cidx     = CH_MS1;
      sidx     = KEY_IDX_W'(KEY_ST1);
      clr_s    = '0;
      clr_c    = '0;
      keys     = '0;
      short_in = '0;
      long_in  = '0;

      // first match wins
      if (pressed[KEY_MOD] && pressed[KEY_ST1]) begin
         cidx  = CH_MS1;
         clr_s = KM_ST2 | KM_ESC;
         clr_c = CM_MS2 | CM_MES | CM_S1E;
         keys  = KM_MOD | KM_ST1;
      end else if (pressed[KEY_MOD] && pressed[KEY_ST2]) begin
         cidx  = CH_MS2;
         clr_s = KM_ST1 | KM_ESC;
         clr_c = CM_MS1 | CM_MES | CM_S1E;
         keys  = KM_MOD | KM_ST2;
      end else if (pressed[KEY_MOD] && pressed[KEY_ESC]) begin
         cidx  = CH_MES;
         clr_s = KM_ST1 | KM_ST2;
         clr_c = CM_MS1 | CM_MS2 | CM_S1E;
         keys  = KM_MOD | KM_ESC;
      end else if (pressed[KEY_ST1] && pressed[KEY_ESC]) begin
         cidx  = CH_S1E;
         clr_s = KM_ST1 | KM_ST2;
         clr_c = CM_MS1 | CM_MS2 | CM_MES;
         keys  = KM_ST1 | KM_ESC;
      end else if (pressed[KEY_ST1] && pressed[KEY_ST2]) begin
         cidx  = CH_S12;
         clr_s = KM_ESC;
         clr_c = CM_MS1 | CM_MS2 | CM_MES | CM_S1E;
         keys  = KM_ST1 | KM_ST2;
      end else if (pressed[KEY_ST1]) begin
         is_chord = 1'b0;
         sidx     = KEY_IDX_W'(KEY_ST1);
         clr_s    = KM_ESC;
         clr_c    = CM_MS1 | CM_MS2 | CM_MES | CM_S1E;
      end else if (pressed[KEY_ST2]) begin
         is_chord = 1'b0;
         sidx     = KEY_IDX_W'(KEY_ST2);
         clr_s    = KM_ESC;
         clr_c    = CM_MS1 | CM_MS2 | CM_MES | CM_S1E;
      end else if (pressed[KEY_ESC]) begin
         is_chord = 1'b0;
         sidx     = KEY_IDX_W'(KEY_ESC);
         clr_s    = KM_ST1 | KM_ST2 | KM_MOD;
         clr_c    = CM_MS1 | CM_MS2 | CM_MES | CM_S1E;
      end else begin
         is_chord = 1'b0;
         sidx     = KEY_IDX_W'(KEY_MOD);
         clr_s    = '0;
         clr_c    = CM_MS1 | CM_MS2 | CM_MES | CM_S1E;
      end

      if (!any_key) begin
         clr_s = KM_ALL;
         clr_c = CM_MS1 | CM_MS2 | CM_MES | CM_S1E | CM_S12;
      end

      for (int i = 0; i < KEY_N; i++) begin
         single_cnt_in[i] = clr_s[i] ? '0 : single_cnt_ff[i];
      end
      for (int i = 0; i < CHORD_N; i++) begin
         chord_cnt_in[i] = clr_c[i] ? '0 : chord_cnt_ff[i];
      end

      if (any_key && is_chord) begin
         cnt = chord_cnt_in[cidx] + CNT_W'(1);
         chord_cnt_in[cidx] = cnt;
         if (cnt == cfg.tact_threshold) begin
            short_in = keys;
         end else if (cnt > cfg.tact_threshold) begin
            chord_cnt_in[cidx] = cfg.limit_value;
         end
      end else if (any_key) begin
         cnt = single_cnt_in[sidx] + CNT_W'(1);
         single_cnt_in[sidx] = cnt;
         if (cnt == cfg.tact_threshold) begin
            short_in = KEY_N'(1) << sidx;
         end else if (cnt == cfg.long_threshold) begin
            long_in = KEY_N'(1) << sidx;
         end else if (cnt > cfg.long_threshold) begin
            long_in = KEY_N'(1) << sidx;
            single_cnt_in[sidx] = cfg.limit_value;
         end
      end else begin
         cnt = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KEY_N; i++) begin
            single_cnt_ff[i] <= '0;
         end
         for (int i = 0; i < CHORD_N; i++) begin
            chord_cnt_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            single_cnt_ff <= single_cnt_in;
            chord_cnt_ff  <= chord_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.short_press_mask = short_ff;
   assign rsp_chan.long_press_mask  = long_ff;

endmodule

// ===== src/button_combo_long_press_scanner_top.sv =====
// A req transfer passes the input register, then the result register, before it shows up as a rsp.
// Throughput: one scan tick per cycle; both stages advance together whenever rsp is not stalled.
// Reset: synchronous, active high. Clears all nine hold counters and both valid flags, and
// loads the thresholds with 5 (tact), 30 (long) and 50 (limit).
module button_combo_long_press_scanner_top import bcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   bcs_req_if.sink             req_chan,
   bcs_rsp_if.source           rsp_chan,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [CNT_W-1:0]    csr_wdata
);

   // threshold registers: the user must see that they are written only while idle; the block leaves this to the user
   logic [CNT_W-1:0] tact_ff;
   logic [CNT_W-1:0] tact_in;
   logic [CNT_W-1:0] long_ff;
   logic [CNT_W-1:0] long_in;
   logic [CNT_W-1:0] limit_ff;
   logic [CNT_W-1:0] limit_in;

   bcs_cfg_type   cfg;
   bcs_stage_type stage;
   logic          core_ready;
   logic          core_fire;

   always_comb begin
      tact_in  = tact_ff;
      long_in  = long_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TACT:  tact_in  = csr_wdata;
            CSR_LONG:  long_in  = csr_wdata;
            CSR_LIMIT: limit_in = csr_wdata;
            default:   ; // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tact_ff  <= TACT_RST;
         long_ff  <= LONG_RST;
         limit_ff <= LIMIT_RST;
      end else begin
         tact_ff  <= tact_in;
         long_ff  <= long_in;
         limit_ff <= limit_in;
      end
   end

   assign cfg.tact_threshold = tact_ff;
   assign cfg.long_threshold = long_ff;
   assign cfg.limit_value    = limit_ff;

   // stage 1: capture the scan tick
   bcs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .core_ready (core_ready),
      .stage      (stage)
   );

   // stage 2: priority decode, counter update, result register
   bcs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .stage      (stage),
      .core_ready (core_ready),
      .rsp_chan   (rsp_chan)
   );

   assign core_fire = stage.valid && core_ready;

   // all keys up never yields an event
   a_idle_no_event: assert property (@(posedge clock) disable iff (reset)
      (core_fire && stage.button_levels == KM_ALL) |=>
      (rsp_chan.short_press_mask == '0 && rsp_chan.long_press_mask == '0))
      else $error("event reported with all keys released");

   // long press is single key only
   a_long_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $onehot0(rsp_chan.long_press_mask))
      else $error("more than one long press bit set");

   // short and long never in the same result
   a_short_xor_long: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !((|rsp_chan.short_press_mask) && (|rsp_chan.long_press_mask)))
      else $error("short and long press in one result");

   // nothing pending straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_chan.valid && !stage.valid))
      else $error("valid set after reset");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Scan-tick test bench for the button scanner.
// One sender offers scan ticks on req_if. One receiver takes results on rsp_if.
// The scoreboard predicts the short and long press masks for every accepted tick.
// Each result transfer is checked against the oldest prediction in order.
module tb_top;
   import bcs_pkg::*;

   // Result latency is two stages; allow a little extra before reconfiguring.
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_LEN   = 300;

   // No register sits at this index, so writes to it must be dropped.
   localparam logic [1:0] CSR_NONE = 2'd3;

   // Chord counters other than start1+start2; most cases clear these.
   localparam logic [CHORD_N-1:0] CM_PAIRS_NO_S12 = CM_MS1 | CM_MS2 | CM_MES | CM_S1E;
   localparam logic [CHORD_N-1:0] CM_PAIRS_ALL    = CM_PAIRS_NO_S12 | CM_S12;

   typedef struct packed {
      logic [KEY_N-1:0] short_mask;
      logic [KEY_N-1:0] long_mask;
   } press_event_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [CNT_W-1:0] csr_wdata;

   bcs_req_if req_if ();
   bcs_rsp_if rsp_if ();

   button_combo_long_press_scanner_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Scoreboard model: thresholds, nine hold counters, expected events
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] tact_thr;
   logic [CNT_W-1:0] long_thr;
   logic [CNT_W-1:0] limit_val;
   logic [CNT_W-1:0] key_hold [KEY_N];
   logic [CNT_W-1:0] chord_hold [CHORD_N];

   press_event_type pending_events [$];

   int  fail_count    = 0;
   bit  idle_on       = 1'b1;   // random gaps on both sides when set
   int  hold_request  = 0;      // receiver picks this up as a long stall
   int  rsp_stall     = 0;
   int  quiet_cycles  = 0;

   function automatic void clear_holds(input logic [KEY_N-1:0] keys,
                                       input logic [CHORD_N-1:0] chords);
      for (int i = 0; i < KEY_N; i++)
         if (keys[i]) key_hold[i] = '0;
      for (int i = 0; i < CHORD_N; i++)
         if (chords[i]) chord_hold[i] = '0;
   endfunction

   // Chord counters report at the tact threshold; past it they are set to the limit value.
   function automatic logic [KEY_N-1:0] chord_step(input int slot,
                                                   input logic [KEY_N-1:0] keys_clr,
                                                   input logic [CHORD_N-1:0] chords_clr,
                                                   input logic [KEY_N-1:0] keys);
      logic [CNT_W-1:0] c;
      clear_holds(keys_clr, chords_clr);
      c = chord_hold[slot] + 6'd1;   // wraps at 6 bits
      chord_hold[slot] = c;
      if (c == tact_thr) return keys;
      if (c > tact_thr) chord_hold[slot] = limit_val;
      return '0;
   endfunction

   // Single keys: short at tact, long from the long threshold on, short wins a tie.
   function automatic press_event_type key_step(input int slot,
                                                input logic [KEY_N-1:0] keys_clr,
                                                input logic [CHORD_N-1:0] chords_clr);
      press_event_type ev;
      logic [CNT_W-1:0] c;
      ev = '0;
      clear_holds(keys_clr, chords_clr);
      c = key_hold[slot] + 6'd1;
      key_hold[slot] = c;
      if (c == tact_thr) begin
         ev.short_mask = KM_ST1 << slot;
      end else if (c == long_thr) begin
         ev.long_mask = KM_ST1 << slot;
      end else if (c > long_thr) begin
         ev.long_mask = KM_ST1 << slot;
         key_hold[slot] = limit_val;
      end
      return ev;
   endfunction

   // One scan tick, first matching case in priority order.
   function automatic press_event_type scan_tick(input logic [KEY_N-1:0] levels);
      logic [KEY_N-1:0] down;
      press_event_type  ev;
      down = ~levels;
      ev   = '0;
      if (down[KEY_MOD] && down[KEY_ST1])
         ev.short_mask = chord_step(CH_MS1, KM_ST2 | KM_ESC,
                                    CM_MS2 | CM_MES | CM_S1E, KM_MOD | KM_ST1);
      else if (down[KEY_MOD] && down[KEY_ST2])
         ev.short_mask = chord_step(CH_MS2, KM_ST1 | KM_ESC,
                                    CM_MS1 | CM_MES | CM_S1E, KM_MOD | KM_ST2);
      else if (down[KEY_MOD] && down[KEY_ESC])
         ev.short_mask = chord_step(CH_MES, KM_ST1 | KM_ST2,
                                    CM_MS1 | CM_MS2 | CM_S1E, KM_MOD | KM_ESC);
      else if (down[KEY_ST1] && down[KEY_ESC])
         ev.short_mask = chord_step(CH_S1E, KM_ST1 | KM_ST2,
                                    CM_MS1 | CM_MS2 | CM_MES, KM_ST1 | KM_ESC);
      else if (down[KEY_ST1] && down[KEY_ST2])
         ev.short_mask = chord_step(CH_S12, KM_ESC, CM_PAIRS_NO_S12, KM_ST1 | KM_ST2);
      else if (down[KEY_ST1])
         ev = key_step(KEY_ST1, KM_ESC, CM_PAIRS_NO_S12);
      else if (down[KEY_ST2])
         ev = key_step(KEY_ST2, KM_ESC, CM_PAIRS_NO_S12);
      else if (down[KEY_ESC])
         ev = key_step(KEY_ESC, KM_ST1 | KM_ST2 | KM_MOD, CM_PAIRS_NO_S12);
      else if (down[KEY_MOD])
         ev = key_step(KEY_MOD, '0, CM_PAIRS_NO_S12);
      else
         clear_holds(KM_ALL, CM_PAIRS_ALL);
      return ev;
   endfunction

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Levels for a held combination; last choice is any set with a key down.
   function automatic logic [KEY_N-1:0] pick_combo();
      case ($urandom_range(0, 9))
         0:       return ~(KM_MOD | KM_ST1);
         1:       return ~(KM_MOD | KM_ST2);
         2:       return ~(KM_MOD | KM_ESC);
         3:       return ~(KM_ST1 | KM_ESC);
         4:       return ~(KM_ST1 | KM_ST2);
         5:       return ~KM_ST1;
         6:       return ~KM_ST2;
         7:       return ~KM_ESC;
         8:       return ~KM_MOD;
         default: return 4'($urandom_range(0, 14));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Sender side. valid is only lowered when a gap follows, so a run of
   // back-to-back transfers never sees valid dropped and raised in one step.
   // ---------------------------------------------------------------------
   task automatic send_scan(input logic [KEY_N-1:0] levels);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.button_levels <= levels;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_events.push_back(scan_tick(levels));
   endtask

   // Stop offering and let every outstanding result come back.
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three thresholds plus the unmapped index, only while idle.
   task automatic load_thresholds(input logic [CNT_W-1:0] tact_v,
                                  input logic [CNT_W-1:0] long_v,
                                  input logic [CNT_W-1:0] limit_v);
      settle_block();
      csr_we    <= 1'b1;
      csr_index <= CSR_TACT;
      csr_wdata <= tact_v;
      @(posedge clock);
      csr_index <= CSR_LONG;
      csr_wdata <= long_v;
      @(posedge clock);
      csr_index <= CSR_LIMIT;
      csr_wdata <= limit_v;
      @(posedge clock);
      csr_index <= CSR_NONE;
      csr_wdata <= 6'($urandom);
      @(posedge clock);
      csr_we    <= 1'b0;
      tact_thr  = tact_v;
      long_thr  = long_v;
      limit_val = limit_v;
   endtask

   // Mostly held combinations, some long enough to pass every threshold, with
   // releases between some of them; a quarter of the picks are single random noise ticks.
   task automatic run_scan_mix(input int count);
      int               sent;
      int               reach;
      int               hold_len;
      logic [KEY_N-1:0] levels;
      sent  = 0;
      reach = ((tact_thr > long_thr) ? tact_thr : long_thr) + 8;
      while (sent < count) begin
         if ($urandom_range(0, 3) == 0) begin
            send_scan(4'($urandom));
            sent++;
         end else begin
            levels   = pick_combo();
            hold_len = $urandom_range(1, reach);
            for (int i = 0; i < hold_len && sent < count; i++) begin
               send_scan(levels);
               sent++;
            end
            if ($urandom_range(0, 1) == 1) begin
               send_scan(KM_ALL);
               sent++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset thresholds 5 / 30 / 50, nothing written yet.
   task automatic test_reset_defaults();
      idle_on = 1'b1;
      run_scan_mix(200);
   endtask

   // Every priority case, both level extremes, limit under the long threshold.
   task automatic test_directed_cases();
      idle_on = 1'b0;
      load_thresholds(6'd2, 6'd3, 6'd2);
      send_scan(KM_ALL);
      send_scan(~(KM_MOD | KM_ST1));
      send_scan(~(KM_MOD | KM_ST1));
      send_scan(~(KM_MOD | KM_ST2));
      send_scan(~(KM_MOD | KM_ST2));
      send_scan(~(KM_MOD | KM_ESC));
      send_scan(~(KM_MOD | KM_ESC));
      send_scan(~(KM_ST1 | KM_ESC));
      send_scan(~(KM_ST1 | KM_ESC));
      send_scan(~(KM_ST1 | KM_ST2));
      send_scan(~(KM_ST1 | KM_ST2));
      for (int i = 0; i < 5; i++) send_scan(~KM_ST1);   // none, short, long, long at the limit, long again
      send_scan(~KM_ST2);
      send_scan(~KM_ST2);
      send_scan(~KM_ESC);
      send_scan(~KM_ESC);
      send_scan(~KM_MOD);
      send_scan(~KM_MOD);
      send_scan(~KM_MOD);
      send_scan('0);                                    // all down: mode+start1 wins
      send_scan(KM_ALL);
   endtask

   // Tact equals long: the short report must win the tie.
   task automatic test_short_and_long_together();
      idle_on = 1'b1;
      load_thresholds(6'd4, 6'd4, 6'd2);
      run_scan_mix(100);
   endtask

   // Zero thresholds: counters snap to the limit on every tick past zero.
   task automatic test_zero_thresholds();
      idle_on = 1'b1;
      load_thresholds(6'd0, 6'd0, 6'd0);
      run_scan_mix(40);
      load_thresholds(6'd0, 6'd0, 6'd63);
      run_scan_mix(40);
   endtask

   // Tact at 63 lets the 6-bit counter wrap back to zero.
   task automatic test_counter_wrap();
      idle_on = 1'b1;
      load_thresholds(6'd63, 6'd61, 6'd62);
      run_scan_mix(150);
   endtask

   // Lowest and highest in-range settings.
   task automatic test_range_extremes();
      idle_on = 1'b1;
      load_thresholds(6'd1, 6'd2, 6'd2);
      run_scan_mix(100);
      load_thresholds(6'd61, 6'd61, 6'd62);
      run_scan_mix(100);
   endtask

   // A few random settings; the last one without any idling.
   task automatic test_random_settings();
      idle_on = 1'b1;
      load_thresholds(6'($urandom_range(1, 12)), 6'($urandom_range(2, 16)),
                      6'($urandom_range(0, 20)));
      run_scan_mix(100);
      load_thresholds(6'($urandom), 6'($urandom), 6'($urandom));
      run_scan_mix(100);
      idle_on = 1'b0;
      load_thresholds(6'($urandom_range(1, 8)), 6'($urandom_range(2, 10)),
                      6'($urandom_range(0, 12)));
      run_scan_mix(100);
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering,
   // so both stages fill and req ready must drop.
   task automatic test_backpressure();
      load_thresholds(TACT_RST, LONG_RST, LIMIT_RST);
      idle_on      = 1'b0;
      hold_request = HOLD_OFF_LEN;
      run_scan_mix(100);
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus the long hold-off counted here
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            rsp_stall    = hold_request;
            hold_request = 0;
         end
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every rsp transfer against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      press_event_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected result, short_press_mask %h long_press_mask %h",
                     $time, rsp_if.short_press_mask, rsp_if.long_press_mask);
            fail_count++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_if.short_press_mask !== want.short_mask) begin
               $display("%0t: short_press_mask expected %h actual %h",
                        $time, want.short_mask, rsp_if.short_press_mask);
               fail_count++;
            end
            if (rsp_if.long_press_mask !== want.long_mask) begin
               $display("%0t: long_press_mask expected %h actual %h",
                        $time, want.long_mask, rsp_if.long_press_mask);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: too many cycles with no transfer on either channel
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("button_combo_long_press_scanner_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_TACT;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.button_levels = KM_ALL;

      tact_thr  = TACT_RST;
      long_thr  = LONG_RST;
      limit_val = LIMIT_RST;
      clear_holds(KM_ALL, CM_PAIRS_ALL);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_cases();
      test_short_and_long_together();
      test_zero_thresholds();
      test_counter_wrap();
      test_range_extremes();
      test_random_settings();
      test_backpressure();

      // drain; the watchdog bounds this wait
      settle_block();

      if (fail_count == 0) begin
         $display("button_combo_long_press_scanner_top test passed");
      end else begin
         $display("button_combo_long_press_scanner_top test failed");
      end
      $finish;
   end

endmodule
